### rtl/bcalc_pkg.sv
// ----------------------------------------------------------------------------
// bcalc_pkg
// Shared types and instruction codes for the decimal calculator step engine.
// ----------------------------------------------------------------------------
package bcalc_pkg;

    localparam int WORD_DIGITS   = 14;
    localparam int DIGIT_BITS    = 4;
    localparam int REG_BITS      = WORD_DIGITS * DIGIT_BITS;
    localparam int FLAG_COUNT    = 16;
    localparam int CLEARED_FLAGS = 12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARITH,
        ST_OUT
    } state_t;

    // low-byte decode patterns
    localparam logic [7:0] L_RETURN    = 8'h30;  // under mask 0x7F
    localparam logic [7:0] L_BANK      = 8'h10;  // under mask 0x7F
    localparam logic [7:0] L_KEYJUMP   = 8'hD0;
    localparam logic [7:0] L_TEST_FLAG = 8'h14;  // under mask 0x3F
    localparam logic [7:0] L_SET_FLAG  = 8'h04;
    localparam logic [7:0] L_CLR_FLAG  = 8'h24;
    localparam logic [7:0] L_CLR_ALL   = 8'h34;
    localparam logic [7:0] L_TEST_PTR  = 8'h2C;
    localparam logic [7:0] L_SET_PTR   = 8'h0C;
    localparam logic [7:0] L_INC_PTR   = 8'h3C;
    localparam logic [7:0] L_DEC_PTR   = 8'h1C;
    localparam logic [7:0] L_LOAD_CON  = 8'h18;
    localparam logic [7:0] L_MOVE_A    = 8'hA8;  // under mask 0xEF
    localparam logic [7:0] L_MOVE_B    = 8'h28;  // under mask 0xEF
    localparam logic [7:0] ERROR_ADDR  = 8'd191;

    localparam logic [1:0] K_NOP    = 2'd0;
    localparam logic [1:0] K_JSB    = 2'd1;
    localparam logic [1:0] K_ARITH  = 2'd2;
    localparam logic [1:0] K_BRANCH = 2'd3;

    // arithmetic operation codes
    localparam logic [4:0] OP_TST_B    = 5'h00;
    localparam logic [4:0] OP_CLR_B    = 5'h01;
    localparam logic [4:0] OP_AMC_T    = 5'h02;
    localparam logic [4:0] OP_TST_CZ   = 5'h03;
    localparam logic [4:0] OP_B_TO_C   = 5'h04;
    localparam logic [4:0] OP_NEG_C    = 5'h05;
    localparam logic [4:0] OP_CLR_C    = 5'h06;
    localparam logic [4:0] OP_NEG_C1   = 5'h07;
    localparam logic [4:0] OP_SHL_A    = 5'h08;
    localparam logic [4:0] OP_A_TO_B   = 5'h09;
    localparam logic [4:0] OP_AMC_C    = 5'h0A;
    localparam logic [4:0] OP_DEC_C    = 5'h0B;
    localparam logic [4:0] OP_C_TO_A   = 5'h0C;
    localparam logic [4:0] OP_TST_C    = 5'h0D;
    localparam logic [4:0] OP_APC_C    = 5'h0E;
    localparam logic [4:0] OP_INC_C    = 5'h0F;
    localparam logic [4:0] OP_AMB_T    = 5'h10;
    localparam logic [4:0] OP_XCH_BC   = 5'h11;
    localparam logic [4:0] OP_SHR_C    = 5'h12;
    localparam logic [4:0] OP_TST_AZ   = 5'h13;
    localparam logic [4:0] OP_SHR_B    = 5'h14;
    localparam logic [4:0] OP_CPC_C    = 5'h15;
    localparam logic [4:0] OP_SHR_A    = 5'h16;
    localparam logic [4:0] OP_CLR_A    = 5'h17;
    localparam logic [4:0] OP_AMB_A    = 5'h18;
    localparam logic [4:0] OP_XCH_AB   = 5'h19;
    localparam logic [4:0] OP_AMC_A    = 5'h1A;
    localparam logic [4:0] OP_DEC_A    = 5'h1B;
    localparam logic [4:0] OP_APB_A    = 5'h1C;
    localparam logic [4:0] OP_XCH_AC   = 5'h1D;
    localparam logic [4:0] OP_APC_A    = 5'h1E;
    localparam logic [4:0] OP_INC_A    = 5'h1F;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic       wa;
        logic       wb;
        logic       wc;
        logic       cy;
    } alu_res_t;

endpackage

### rtl/bcalc_digit_alu.sv
// ----------------------------------------------------------------------------
// bcalc_digit_alu
// One-digit slice of the register arithmetic: decimal add/subtract, moves,
// exchanges, tests and shifts, with the carry passed digit to digit.
// ----------------------------------------------------------------------------
module bcalc_digit_alu
(
    input  logic [4:0]          op,
    input  logic [3:0]          a,
    input  logic [3:0]          b,
    input  logic [3:0]          c,
    input  logic [3:0]          prev,      // original A digit one below
    input  logic [3:0]          up,        // shifted register, digit one above
    input  logic                is_first,
    input  logic                is_last,
    input  logic                cy_in,
    output bcalc_pkg::alu_res_t res
);
    import bcalc_pkg::*;

    function automatic logic [4:0] dadd(input logic [3:0] x, input logic [3:0] y,
                                        input logic ci);
        logic [4:0] s;
        begin
            s = {1'b0, x} + {1'b0, y} + {4'b0, ci};
            if (s > 5'd9)
            begin
                s = s - 5'd10;
                dadd = {1'b1, s[3:0]};
            end
            else
            begin
                dadd = {1'b0, s[3:0]};
            end
        end
    endfunction

    function automatic logic [4:0] dsub(input logic [3:0] x, input logic [3:0] y,
                                        input logic ci);
        logic [5:0] s;
        begin
            s = {2'b0, x} - {2'b0, y} - {5'b0, ci};
            if (s[5])
            begin
                s = s + 6'd10;
                dsub = {1'b1, s[3:0]};
            end
            else
            begin
                dsub = {1'b0, s[3:0]};
            end
        end
    endfunction

    logic [4:0] r;

    always_comb
    begin
        res = '{a: a, b: b, c: c, wa: 1'b0, wb: 1'b0, wc: 1'b0, cy: cy_in};
        r   = 5'd0;
        case (op)
            OP_TST_B:  if (b != 4'd0) res.cy = 1'b1;
            OP_CLR_B:  begin res.b = 4'd0; res.wb = 1'b1; end
            OP_AMC_T, OP_AMB_T:
            begin
                // scratch register result is never observed; carry only
                r = (op == OP_AMC_T) ? dsub(a, c, cy_in) : dsub(a, b, cy_in);
                res.cy = r[4];
            end
            OP_TST_CZ: if (c != 4'd0) res.cy = 1'b0;
            OP_B_TO_C: begin res.c = b; res.wc = 1'b1; end
            OP_NEG_C, OP_NEG_C1:
            begin
                r = dsub(4'd0, c, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_CLR_C:  begin res.c = 4'd0; res.wc = 1'b1; end
            OP_SHL_A:  begin res.a = is_first ? 4'd0 : prev; res.wa = 1'b1; end
            OP_A_TO_B: begin res.b = a; res.wb = 1'b1; end
            OP_AMC_C:
            begin
                r = dsub(a, c, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_DEC_C:
            begin
                r = dsub(c, 4'd0, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_C_TO_A: begin res.a = c; res.wa = 1'b1; end
            OP_TST_C:  if (c != 4'd0) res.cy = 1'b1;
            OP_APC_C:
            begin
                r = dadd(a, c, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_INC_C:
            begin
                r = dadd(c, 4'd0, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_XCH_BC: begin res.b = c; res.c = b; res.wb = 1'b1; res.wc = 1'b1; end
            OP_SHR_C:  begin res.c = is_last ? 4'd0 : up; res.wc = 1'b1; end
            OP_TST_AZ: if (a != 4'd0) res.cy = 1'b0;
            OP_SHR_B:  begin res.b = is_last ? 4'd0 : up; res.wb = 1'b1; end
            OP_CPC_C:
            begin
                r = dadd(c, c, cy_in);
                res.c = r[3:0]; res.wc = 1'b1; res.cy = r[4];
            end
            OP_SHR_A:  begin res.a = is_last ? 4'd0 : up; res.wa = 1'b1; end
            OP_CLR_A:  begin res.a = 4'd0; res.wa = 1'b1; end
            OP_AMB_A:
            begin
                r = dsub(a, b, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            OP_XCH_AB: begin res.a = b; res.b = a; res.wa = 1'b1; res.wb = 1'b1; end
            OP_AMC_A:
            begin
                r = dsub(a, c, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            OP_DEC_A:
            begin
                r = dsub(a, 4'd0, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            OP_APB_A:
            begin
                r = dadd(a, b, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            OP_XCH_AC: begin res.a = c; res.c = a; res.wa = 1'b1; res.wc = 1'b1; end
            OP_APC_A:
            begin
                r = dadd(a, c, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            OP_INC_A:
            begin
                r = dadd(a, 4'd0, cy_in);
                res.a = r[3:0]; res.wa = 1'b1; res.cy = r[4];
            end
            default: ;
        endcase
    end

endmodule

### rtl/bcd_calculator_cpu_step_top.sv
// ----------------------------------------------------------------------------
// bcd_calculator_cpu_step_top
// Decimal calculator processor executing one instruction per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one instruction (plus an optional keypress);
// one result transfer follows with the next fetch address, ROM bank, error
// and display state, and registers A and B. The block works on one
// instruction at a time and accepts input only while idle. Control, flag,
// pointer and register-move instructions execute at the accepting edge and
// the result is offered in the next cycle. Arithmetic walks its digit range
// one digit per cycle through a single digit ALU, from the first to the last
// digit of its field, before the result is offered in the output state. The
// result is held until the receiver takes it.
module bcd_calculator_cpu_step_top #(
    parameter int CLEARED_FLAGS = bcalc_pkg::CLEARED_FLAGS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] instruction, [10] key_pending, [18:11] key_value
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] fetch_address, [10:8] rom_bank, [11] error_flag, [12] display_on,
    // [68:13] a_digits, [124:69] b_digits
    output logic [127:0] m_tdata
);
    import bcalc_pkg::*;

    function automatic logic [3:0] dig(input logic [REG_BITS-1:0] r,
                                       input logic [4:0] k);
        begin
            if (k < 5'(WORD_DIGITS))
                dig = r[{k[3:0], 2'b00} +: DIGIT_BITS];
            else
                dig = 4'd0;
        end
    endfunction

    function automatic logic [REG_BITS-1:0] dput(input logic [REG_BITS-1:0] r,
                                                 input logic [3:0] k,
                                                 input logic [3:0] v);
        logic [REG_BITS-1:0] o;
        begin
            o = r;
            for (int n = 0; n < WORD_DIGITS; n++)
                if (k == 4'(n))
                    o[n*DIGIT_BITS +: DIGIT_BITS] = v;
            dput = o;
        end
    endfunction

    state_t state_reg, state_next;

    logic [REG_BITS-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, m_reg;
    logic [REG_BITS-1:0] a_next, b_next, c_next, d_next, e_next, f_next, m_next;
    logic [15:0] flags_reg, flags_next;
    logic [3:0]  ptr_reg, ptr_next;
    logic [7:0]  pc_reg, pc_next;
    logic [7:0]  ret_reg, ret_next;
    logic [2:0]  bank_reg, bank_next;
    logic        carry_reg, carry_next;
    logic        pcarry_reg, pcarry_next;
    logic [7:0]  key_reg, key_next;
    logic        err_reg, err_next;
    logic        disp_reg, disp_next;
    logic [4:0]  op_reg, op_next;
    logic [3:0]  dig_reg, dig_next;
    logic [3:0]  first_reg, first_next;
    logic [3:0]  last_reg, last_next;
    logic [3:0]  prev_reg, prev_next;

    logic [9:0]  instr;
    logic        key_pending;
    logic [7:0]  key_value;
    logic [1:0]  h;
    logic [7:0]  l;
    logic [3:0]  idx;
    logic        in_xfer;
    logic        is_arith;

    logic [3:0]  da, db, dc, dup;
    alu_res_t    alu_res;

    assign instr       = s_tdata[9:0];
    assign key_pending = s_tdata[10];
    assign key_value   = s_tdata[18:11];
    assign h           = instr[9:8];
    assign l           = instr[7:0];
    assign idx         = {h, l[7:6]};
    assign in_xfer     = s_tvalid && s_tready;
    assign is_arith    = (l[1:0] == K_ARITH);

    // digit read for the serial walk
    assign da = dig(a_reg, {1'b0, dig_reg});
    assign db = dig(b_reg, {1'b0, dig_reg});
    assign dc = dig(c_reg, {1'b0, dig_reg});

    always_comb
    begin
        case (op_reg)
            OP_SHR_C: dup = dig(c_reg, {1'b0, dig_reg} + 5'd1);
            OP_SHR_B: dup = dig(b_reg, {1'b0, dig_reg} + 5'd1);
            default:  dup = dig(a_reg, {1'b0, dig_reg} + 5'd1);
        endcase
    end

    bcalc_digit_alu u_alu
    (
        .op       (op_reg),
        .a        (da),
        .b        (db),
        .c        (dc),
        .prev     (prev_reg),
        .up       (dup),
        .is_first (dig_reg == first_reg),
        .is_last  (dig_reg == last_reg),
        .cy_in    (carry_reg),
        .res      (alu_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = is_arith ? ST_ARITH : ST_OUT;
            ST_ARITH: if (dig_reg == last_reg) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [REG_BITS-1:0] tmp;
        logic [7:0] pc1;
        logic       pcy;

        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; f_next = f_reg; m_next = m_reg;
        flags_next = flags_reg; ptr_next = ptr_reg; pc_next = pc_reg;
        ret_next = ret_reg; bank_next = bank_reg; carry_next = carry_reg;
        pcarry_next = pcarry_reg; key_next = key_reg; err_next = err_reg;
        disp_next = disp_reg; op_next = op_reg; dig_next = dig_reg;
        first_next = first_reg; last_next = last_reg; prev_next = prev_reg;
        tmp = c_reg;
        pc1 = pc_reg + 8'd1;
        pcy = carry_reg;

        if (state_reg == ST_IDLE && in_xfer)
        begin
            if (pc_reg == ERROR_ADDR && bank_reg == 3'd0)
                err_next = 1'b1;
            pcarry_next = pcy;
            carry_next  = 1'b0;
            pc_next     = pc1;
            if (key_pending)
            begin
                err_next      = 1'b0;
                key_next      = key_value;
                flags_next[0] = 1'b1;
            end

            if (l[1:0] == K_JSB)
            begin
                ret_next = pc1;
                pc_next  = {h, l[7:2]};
            end
            if ((l & 8'h7F) == L_RETURN) pc_next = ret_reg;
            if ((l & 8'h7F) == L_BANK)   bank_next = {h, l[7]};
            if (l == L_KEYJUMP)
            begin
                pc_next       = key_next;
                flags_next[0] = 1'b0;
            end
            if ((l & 8'h3F) == L_TEST_FLAG) carry_next = flags_next[idx];
            if ((l & 8'h3F) == L_SET_FLAG)  flags_next[idx] = 1'b1;
            if ((l & 8'h3F) == L_CLR_FLAG)  flags_next[idx] = 1'b0;
            if ((l & 8'h3F) == L_CLR_ALL)
                for (int k = 0; k < FLAG_COUNT; k++)
                    if (k < CLEARED_FLAGS)
                        flags_next[k] = 1'b0;
            if ((l & 8'h3F) == L_TEST_PTR) carry_next = (ptr_reg == idx);
            if ((l & 8'h3F) == L_SET_PTR)  ptr_next = idx;
            if ((l & 8'h3F) == L_INC_PTR)  ptr_next = ptr_reg + 4'd1;
            if ((l & 8'h3F) == L_DEC_PTR)  ptr_next = ptr_reg - 4'd1;
            if ((l & 8'h3F) == L_LOAD_CON)
            begin
                c_next   = dput(c_reg, ptr_reg, idx);
                ptr_next = ptr_reg - 4'd1;
            end
            if ((l & 8'hEF) == L_MOVE_A)
            begin
                case (h)
                    2'd0:    begin c_next = m_reg; m_next = c_reg; end
                    2'd1:    begin a_next = d_reg; d_next = e_reg; e_next = f_reg; end
                    2'd2:    c_next = m_reg;
                    default:
                    begin
                        a_next = '0; b_next = '0; c_next = '0; d_next = '0;
                        e_next = '0; f_next = '0; m_next = '0;
                    end
                endcase
            end
            if ((l & 8'hEF) == L_MOVE_B)
            begin
                case (h)
                    2'd0:    disp_next = 1'b0;
                    2'd1:    begin f_next = e_reg; e_next = d_reg; d_next = c_reg; end
                    2'd2:    disp_next = !disp_reg;
                    default:
                    begin
                        tmp = c_reg;
                        c_next = d_reg; d_next = e_reg; e_next = f_reg; f_next = tmp;
                    end
                endcase
            end
            if (l[1:0] == K_BRANCH && !pcy)
                pc_next = {h, l[7:2]};

            if (is_arith)
            begin
                op_next = {h, l[7:5]};
                case (l[4:2])
                    3'd0:    begin first_next = ptr_reg; last_next = ptr_reg; end
                    3'd1:    begin first_next = 4'd3;    last_next = 4'd12;   end
                    3'd2:    begin first_next = 4'd0;    last_next = 4'd2;    end
                    3'd3:    begin first_next = 4'd0;    last_next = 4'd13;   end
                    3'd4:    begin first_next = 4'd0;    last_next = ptr_reg; end
                    3'd5:    begin first_next = 4'd3;    last_next = 4'd13;   end
                    3'd6:    begin first_next = 4'd2;    last_next = 4'd2;    end
                    default: begin first_next = 4'd13;   last_next = 4'd13;   end
                endcase
                dig_next  = first_next;
                prev_next = 4'd0;
                case (op_next)
                    OP_TST_CZ, OP_NEG_C1, OP_DEC_C, OP_INC_C,
                    OP_TST_AZ, OP_DEC_A, OP_INC_A: carry_next = 1'b1;
                    default:                       carry_next = 1'b0;
                endcase
            end
        end
        else if (state_reg == ST_ARITH)
        begin
            if (alu_res.wa) a_next = dput(a_reg, dig_reg, alu_res.a);
            if (alu_res.wb) b_next = dput(b_reg, dig_reg, alu_res.b);
            if (alu_res.wc) c_next = dput(c_reg, dig_reg, alu_res.c);
            carry_next = alu_res.cy;
            prev_next  = da;
            dig_next   = dig_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            d_reg      <= '0;
            e_reg      <= '0;
            f_reg      <= '0;
            m_reg      <= '0;
            flags_reg  <= '0;
            ptr_reg    <= '0;
            pc_reg     <= '0;
            ret_reg    <= '0;
            bank_reg   <= '0;
            carry_reg  <= 1'b0;
            pcarry_reg <= 1'b0;
            key_reg    <= '0;
            err_reg    <= 1'b0;
            disp_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            d_reg      <= d_next;
            e_reg      <= e_next;
            f_reg      <= f_next;
            m_reg      <= m_next;
            flags_reg  <= flags_next;
            ptr_reg    <= ptr_next;
            pc_reg     <= pc_next;
            ret_reg    <= ret_next;
            bank_reg   <= bank_next;
            carry_reg  <= carry_next;
            pcarry_reg <= pcarry_next;
            key_reg    <= key_next;
            err_reg    <= err_next;
            disp_reg   <= disp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        dig_reg   <= dig_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        prev_reg  <= prev_next;
    end

    // previous carry is kept as machine state but drives no output; the branch
    // reads the carry register itself at the start of the next instruction
    assign m_tdata = {3'b000, b_reg, a_reg, disp_reg, err_reg | (pcarry_reg & 1'b0),
                      bank_reg, pc_reg};

endmodule
